// ===== rtl/core/rha_pkg.sv =====
// Package with the shared types and codes of the reference-counted handle allocator.
`default_nettype none

package rha_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned HandleW = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 2;

  // Function codes of a request; the fourth code is unused and is answered as a count error.
  localparam logic [FuncW-1:0] FuncAlloc = 2'd0;
  localparam logic [FuncW-1:0] FuncAdd   = 2'd1;
  localparam logic [FuncW-1:0] FuncDrop  = 2'd2;

  // Status codes of a result.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StNoFree   = 2'd1;
  localparam logic [StatusW-1:0] StCountErr = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [HandleW-1:0] handle_in;
    logic [WordW-1:0]   resource_word;
    logic [WordW-1:0]   metadata_word;
  } rha_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HandleW-1:0] handle_out;
    logic [CountW-1:0]  new_count;
    logic               released;
    logic [WordW-1:0]   released_resource;
    logic [WordW-1:0]   released_metadata;
  } rha_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/refcounted_handle_allocator.sv =====
// Top level of the reference-counted handle allocator with its free stack and handle table.
//
//   channel   | ports                         | handshake
//   ----------+-------------------------------+--------------------------------------------
//   request   | start_i, busy_o, req_i        | taken at a rising edge with start_i & !busy_o
//   result    | done_o, rsp_o                 | one cycle wide, taken at the edge ending it
//
// At the accepting edge of a transaction the free stack and the handle table (one
// synchronous memory each) are read; in the following busy cycle the result is computed
// and each memory is written where the transaction changes it; the result is shown for
// one cycle after. No new request is taken during the handle table's read-modify-write.
// Reset takes effect at once and needs no clearing pass: a low-water mark of the stack
// pointer tells which stack entries and which table rows still hold their reset contents.
// The receiver of results cannot stall; a new request may be taken while a result is shown.
`default_nettype none

module refcounted_handle_allocator import rha_pkg::*; #(
  parameter int unsigned NUM_HANDLES = 256,
  parameter int unsigned COUNT_MAX   = 65535
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire rha_req_t req_i,
  output logic          done_o,
  output rha_rsp_t      rsp_o
);

  localparam int unsigned IdxW = $clog2(NUM_HANDLES);
  localparam int unsigned TopW = IdxW + 1;
  localparam int unsigned CntW = $clog2(longint'(COUNT_MAX) + 64'd1);

  localparam logic [TopW-1:0] TopFull  = TopW'(NUM_HANDLES);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(NUM_HANDLES - 1);
  localparam logic [CntW-1:0] CntMax   = CntW'(COUNT_MAX);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);

  // One row of the handle table: the reference count and the two stored words.
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [WordW-1:0] res;
    logic [WordW-1:0] meta;
  } row_t;

  // Memories. The stack holds free handles, the table is indexed by handle.
  logic [IdxW-1:0] stack_mem [NUM_HANDLES];
  row_t            row_mem   [NUM_HANDLES];

  // Control state.
  logic            busy_q;
  logic            done_q;
  logic [TopW-1:0] top_q, top_d;
  // Lowest value the stack pointer has reached since reset. Stack entries below it were never
  // written and still hold their reset value; handles at or above NUM_HANDLES - lw_q were never
  // allocated, so their count reads as zero.
  logic [TopW-1:0] lw_q, lw_d;

  // Transaction registers of the busy cycle.
  rha_req_t        req_q;
  logic [IdxW-1:0] stk_rd_q;
  row_t            row_rd_q;
  logic            pristine_q;
  logic [IdxW-1:0] pris_val_q;
  logic            cnt_vld_q;
  logic            bad_h_q;
  rha_rsp_t        rsp_q, rsp_d;

  // Write ports.
  logic            stk_we;
  logic [IdxW-1:0] stk_wa;
  logic [IdxW-1:0] stk_wd;
  logic            row_we;
  logic [IdxW-1:0] row_wa;
  row_t            row_wd;

  logic            accept;
  logic [TopW-1:0] top_dec;
  logic [IdxW-1:0] stk_idx;
  logic [IdxW-1:0] h_idx;
  logic [TopW-1:0] alloc_limit;
  logic [IdxW-1:0] nh;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_dec;

  assign accept      = start_i & ~busy_q;
  assign top_dec     = top_q - TopW'(1);
  // The stack top sits one below the pointer; the pointer does not move while busy.
  assign stk_idx     = top_dec[IdxW-1:0];
  assign h_idx       = IdxW'(req_i.handle_in);
  assign alloc_limit = TopFull - lw_q;

  // Memory ports: reads at the accepting edge, writes at the end of the busy cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stk_rd_q <= stack_mem[stk_idx];
      row_rd_q <= row_mem[h_idx];
    end
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
  end

  // Request capture together with the checks that depend on the state at acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_i;
      pristine_q <= ({1'b0, stk_idx} < lw_q);
      pris_val_q <= IdxLast - stk_idx;
      cnt_vld_q  <= ({1'b0, h_idx} < alloc_limit);
      bad_h_q    <= (32'(req_i.handle_in) >= NUM_HANDLES);
    end
  end

  // The handle on top of the stack, and the current count of the requested handle.
  assign nh      = pristine_q ? pris_val_q : stk_rd_q;
  assign cnt     = cnt_vld_q ? row_rd_q.count : '0;
  assign cnt_dec = cnt - CntOne;

  always_comb begin
    top_d  = top_q;
    lw_d   = lw_q;
    stk_we = 1'b0;
    stk_wa = top_q[IdxW-1:0];
    stk_wd = IdxW'(req_q.handle_in);
    row_we = 1'b0;
    row_wa = IdxW'(req_q.handle_in);
    row_wd = '{count: cnt, res: row_rd_q.res, meta: row_rd_q.meta};

    rsp_d                   = '0;
    rsp_d.status            = StCountErr;
    rsp_d.handle_out        = req_q.handle_in;

    unique case (req_q.func)
      FuncAlloc: begin
        rsp_d.handle_out = '0;
        if (top_q == '0) begin
          rsp_d.status = StNoFree;
        end else begin
          top_d = top_dec;
          if (pristine_q) begin
            lw_d = {1'b0, stk_idx};
          end
          row_we = 1'b1;
          row_wa = nh;
          row_wd = '{count: CntOne, res: req_q.resource_word, meta: req_q.metadata_word};
          rsp_d.status     = StOk;
          rsp_d.handle_out = HandleW'(nh);
          rsp_d.new_count  = CountW'(CntOne);
        end
      end
      FuncAdd: begin
        if (!bad_h_q && cnt != '0) begin
          if (cnt >= CntMax) begin
            rsp_d.new_count = CountW'(CntMax);
          end else begin
            row_we          = 1'b1;
            row_wd.count    = cnt + CntOne;
            rsp_d.status    = StOk;
            rsp_d.new_count = CountW'(cnt + CntOne);
          end
        end
      end
      FuncDrop: begin
        if (!bad_h_q && cnt != '0) begin
          row_we          = 1'b1;
          row_wd.count    = cnt_dec;
          rsp_d.status    = StOk;
          rsp_d.new_count = CountW'(cnt_dec);
          if (cnt_dec == '0) begin
            // Last reference gone: the handle returns to the stack if it has room, and its words go out.
            if (top_q < TopFull) begin
              stk_we = 1'b1;
              top_d  = top_q + TopW'(1);
            end
            rsp_d.released          = 1'b1;
            rsp_d.released_resource = row_rd_q.res;
            rsp_d.released_metadata = row_rd_q.meta;
          end
        end
      end
      default: begin
        rsp_d.status = StCountErr;
      end
    endcase

    // Nothing is written outside the busy cycle.
    if (!busy_q) begin
      top_d  = top_q;
      lw_d   = lw_q;
      stk_we = 1'b0;
      row_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      top_q  <= TopFull;
      lw_q   <= TopFull;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      top_q  <= top_d;
      lw_q   <= lw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/rha_checker.sv =====
// Port checker of the reference-counted handle allocator and its bind statement.
`default_nettype none

module rha_checker import rha_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire logic     busy_o,
  input wire rha_req_t req_i,
  input wire logic     done_o,
  input wire rha_rsp_t rsp_o
);

  // An accepted transaction keeps the block busy for one cycle and then shows its result.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o) ##1 (done_o && !busy_o))
    else $error("accepted transaction did not complete in two cycles");

  // No result appears without a transaction that was accepted and then passed through the busy state.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted transaction");

  // A release is a successful drop that leaves a zero count.
  a_release_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.released) |-> (rsp_o.status == StOk && rsp_o.new_count == '0
      && $past(req_i.func, 2) == FuncDrop))
    else $error("release reported on a transaction that cannot free a handle");

  // An exhausted pool answers with handle zero and frees nothing.
  a_no_free_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == StNoFree) |-> (rsp_o.handle_out == '0 && !rsp_o.released
      && rsp_o.new_count == '0))
    else $error("failed allocation carries a handle, a count or a release");

endmodule

bind refcounted_handle_allocator rha_checker u_rha_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
